FILE: hdl/spq_pkg.sv
// shared types and constants for the stable priority queue
package spq_pkg;

  localparam int TAG_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int STAMP_W = 32;
  localparam int OCC_W   = 5;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STS_ADDED     = 2'd0,
    STS_COMPLETED = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WALK,
    S_DEL_HEAD,
    S_DEL_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [TAG_W-1:0]   task_tag;
    logic [PRIO_W-1:0]  priority_req;
    logic [STAMP_W-1:0] stamp;
  } req_item_t;

  typedef struct packed {
    status_e            status;
    logic [TAG_W-1:0]   out_tag;
    logic [PRIO_W-1:0]  out_priority;
    logic [STAMP_W-1:0] out_stamp;
    logic [OCC_W-1:0]   occupancy;
  } rsp_item_t;

endpackage

FILE: hdl/spq_mem.sv
// entry store: one write port, one read port with registered read data
module spq_mem import spq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/stable_priority_queue.sv
// stable priority queue: sorted entry store walked by a small sequencer
// add: moves k entries back one slot, k = entries moved back (0..count), then writes the new entry;
//   complete takes the head and moves the rest up; full add and empty complete only report status
// throughput: one item at a time; the one read port and one write port of the entry store
//   move one entry per cycle
// reset: synchronous, clears the sequencer, the entry count and the result valid;
//   stored entries are not cleared and are never read before they are written
module stable_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int EW = TAG_W + PW + STAMP_W;

  state_e          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic [EW-1:0]   new_ent;
  logic            load_new;
  rsp_item_t       pend, pend_next;
  rsp_item_t       rsp_fill;
  logic            rsp_load;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [EW-1:0]   rdata;

  logic [PW-1:0]   rd_prio, new_prio;
  logic [OCC_W+CW-1:0] count_wide;

  assign rd_prio    = rdata[STAMP_W +: PW];
  assign new_prio   = new_ent[STAMP_W +: PW];
  assign count_wide = {{OCC_W{1'b0}}, count};
  assign req_ready  = (state == S_IDLE);
  assign rsp_load   = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  spq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pend <= pend_next;
    if (load_new) begin
      new_ent <= {req.task_tag, req.priority_req[PW-1:0], req.stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_fill           = pend;
    rsp_fill.occupancy = count_wide[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_fill;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pend_next  = pend;
    load_new   = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = new_ent;
    raddr      = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          pend_next = '0;
          case (req.op)
            OP_ADD: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                pend_next.status = STS_FULL;
                state_next       = S_FINISH;
              end else begin
                load_new = 1'b1;
                idx_next = count;
                if (count != '0) begin
                  raddr = AW'(count - 1'b1);
                end
                state_next = S_ADD_WALK;
              end
            end
            OP_COMPLETE: begin
              if (count == '0) begin
                pend_next.status = STS_EMPTY;
                state_next       = S_FINISH;
              end else begin
                idx_next   = CW'(1);
                state_next = S_DEL_HEAD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_WALK: begin
        // rdata holds entry idx-1; strictly larger priority values move back one slot
        we    = 1'b1;
        waddr = idx[AW-1:0];
        if (idx != '0 && rd_prio > new_prio) begin
          wdata    = rdata;
          idx_next = idx - 1'b1;
          if (idx >= CW'(2)) begin
            raddr = AW'(idx - CW'(2));
          end
        end else begin
          wdata            = new_ent;
          count_next       = count + 1'b1;
          pend_next.status = STS_ADDED;
          state_next       = S_FINISH;
        end
      end
      S_DEL_HEAD: begin
        pend_next.status       = STS_COMPLETED;
        pend_next.out_tag      = rdata[EW-1 -: TAG_W];
        pend_next.out_priority = PRIO_W'(rd_prio);
        pend_next.out_stamp    = rdata[STAMP_W-1:0];
        if (count > CW'(1)) begin
          raddr      = AW'(1);
          state_next = S_DEL_SHIFT;
        end else begin
          count_next = count - 1'b1;
          state_next = S_FINISH;
        end
      end
      S_DEL_SHIFT: begin
        // rdata holds entry idx, moved up to idx-1
        we    = 1'b1;
        waddr = AW'(idx - 1'b1);
        wdata = rdata;
        if ((idx + 1'b1) < count) begin
          raddr    = AW'(idx + 1'b1);
          idx_next = idx + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_WALK |-> idx <= count)
    else $error("insert walk beyond tail");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STS_FULL |-> rsp.occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full status without full occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STS_EMPTY |-> rsp.occupancy == '0)
    else $error("empty status with entries queued");

endmodule
